/* rtl/upd_pkg.sv */
// Package: transaction types, phase encoding, character codes and digit conversion.
`timescale 1ns / 1ps

package upd_pkg;

  // Input transaction: one encoded character
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upd_in_t;

  // Output transaction: one decoded character
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_truncated;
  } upd_out_t;

  // Escape tracking
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_t;

  // Result of decoding one character, handed to the output stage
  typedef struct packed {
    logic     emit;
    upd_out_t res;
  } upd_dec_t;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CASE_MASK  = 8'hDF;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  // Lenient hex digit value, modulo 256
  function automatic logic [7:0] digit_value(input logic [7:0] d);
    logic [7:0] v;
    if (d >= CH_UPPER_A) begin
      v = (d & CASE_MASK) - CH_UPPER_A + LETTER_OFS;
    end else begin
      v = d - CH_ZERO;
    end
    return v;
  endfunction

endpackage

/* rtl/upd_in_stage.sv */
// Input register stage: holds one accepted transaction for the decoder.
`timescale 1ns / 1ps

module upd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  upd_pkg::upd_in_t in_data,
  input  logic             advance,
  output logic             item_valid,
  output upd_pkg::upd_in_t item
);
  import upd_pkg::*;

  logic    valid_r;
  upd_in_t data_r;

  // Take a new transaction when empty or when the held one moves on
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

/* rtl/upd_decode.sv */
// Decoder: escape state machine and per-character result logic.
`timescale 1ns / 1ps

module upd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  upd_pkg::upd_in_t  item,
  output upd_pkg::upd_dec_t dec
);
  import upd_pkg::*;

  upd_phase_t phase_r, phase_nxt;
  logic [3:0] nibble_r, nibble_nxt;
  logic [7:0] ch;
  logic [7:0] dv;
  logic [7:0] pair;

  // Map plus to space before anything else
  assign ch   = (item.in_byte == CH_PLUS) ? CH_SPACE : item.in_byte;
  assign dv   = digit_value(ch);
  assign pair = {nibble_r, 4'b0000} + dv;

  // Next state
  always_comb begin
    phase_nxt  = PH_IDLE;
    nibble_nxt = 4'd0;
    unique case (phase_r)
      PH_PCT: begin
        if (!item.in_last) begin
          phase_nxt  = PH_DIGIT;
          nibble_nxt = dv[3:0];
        end
      end
      PH_DIGIT: begin
        phase_nxt  = PH_IDLE;
        nibble_nxt = 4'd0;
      end
      default: begin
        if (ch == CH_PERCENT) begin
          phase_nxt = item.in_last ? PH_IDLE : PH_PCT;
        end else begin
          nibble_nxt = item.in_last ? 4'd0 : nibble_r;
        end
      end
    endcase
  end

  // Result
  always_comb begin
    dec.emit              = 1'b0;
    dec.res.out_byte      = 8'd0;
    dec.res.out_last      = item.in_last;
    dec.res.out_truncated = 1'b0;
    unique case (phase_r)
      PH_PCT: begin
        dec.emit              = item.in_last;
        dec.res.out_truncated = item.in_last;
      end
      PH_DIGIT: begin
        dec.emit         = 1'b1;
        dec.res.out_byte = pair;
      end
      default: begin
        if (ch == CH_PERCENT) begin
          dec.emit              = item.in_last;
          dec.res.out_truncated = item.in_last;
        end else begin
          dec.emit         = 1'b1;
          dec.res.out_byte = ch;
        end
      end
    endcase
  end

  // Advance escape state once per consumed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      nibble_r <= 4'd0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      nibble_r <= nibble_nxt;
    end
  end

endmodule

/* rtl/upd_out_stage.sv */
// Output register stage: holds one decoded transaction until taken.
`timescale 1ns / 1ps

module upd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  upd_pkg::upd_out_t res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output upd_pkg::upd_out_t out_data
);
  import upd_pkg::*;

  logic     valid_r;
  upd_out_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_r <= res;
    end
  end

endmodule

/* rtl/url_percent_decoder.sv */
// Top level: percent decoder for form-urlencoded byte streams.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | upd_in_t  (in_byte, in_last)
//   out_    | output    | out_valid / out_ready | upd_out_t (out_byte, out_last, out_truncated)
//
// One byte per cycle unless the output stalls; results wait in the result register until taken.
// Each byte is decoded in one pass of logic between the input and result registers.
// Synchronous active-low reset clears valids and the escape state.
// A stalled output holds its result and blocks the input register only when that
// byte would produce a result; a percent sign or first hex digit that is not last moves on regardless.
`timescale 1ns / 1ps

module url_percent_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  upd_pkg::upd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output upd_pkg::upd_out_t out_data
);
  import upd_pkg::*;

  logic     item_valid;
  upd_in_t  item;
  upd_dec_t dec;
  logic     can_load;
  logic     advance;

  // Move the held byte on when its result (if any) has room
  assign advance = item_valid && (!dec.emit || can_load);

  upd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  upd_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .dec     (dec)
  );

  upd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && dec.emit),
    .res       (dec.res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
